// ----- sv/ssd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssd_pkg: shared types and constants of the string splitter
// Sizes of the delimiter window and string counter, register indexes, and
// the structs that carry per-string state and result batches.
// ----------------------------------------------------------------------------
package ssd_pkg;

    localparam int MAX_DELIM_BYTES  = 8;
    localparam int MAX_STRING_BYTES = 8192;

    localparam int DELIM_W = 8 * MAX_DELIM_BYTES;              // delimiter register
    localparam int LEN_W   = $clog2(MAX_DELIM_BYTES + 1);      // 0..MAX_DELIM_BYTES
    localparam int WCNT_W  = $clog2(MAX_DELIM_BYTES);          // window fill 0..MAX-1
    localparam int SLEN_W  = $clog2(MAX_STRING_BYTES);         // string byte count
    localparam int SPLIT_W = SLEN_W;                           // split counter
    localparam int LIMIT_W = SPLIT_W + 1;                      // signed split limit
    localparam int CFG_W   = DELIM_W;                          // widest register
    localparam int DATA_W  = 8;

    localparam logic [SLEN_W-1:0]  SLEN_MAX   = SLEN_W'(MAX_STRING_BYTES - 1);
    localparam logic [SPLIT_W-1:0] SPLITS_MAX = '1;

    localparam logic [DELIM_W-1:0] DELIM_RESET = DELIM_W'(44);   // ','
    localparam logic [LEN_W-1:0]   DLEN_RESET  = LEN_W'(1);
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = '1;             // -1, unlimited

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_DELIM_BYTES = 2'd0,
        CFG_DELIM_LEN   = 2'd1,
        CFG_SPLIT_LIMIT = 2'd2
    } t_cfg_idx;

    // per-string state
    typedef struct packed {
        logic [MAX_DELIM_BYTES-1:0][7:0] window;
        logic [WCNT_W-1:0]               wcnt;
        logic [SPLIT_W-1:0]              splits;
        logic [SLEN_W-1:0]               slen;
        logic                            ovf;
    } t_state;

    // results of one item: cnt token bytes from the front of bytes, then an
    // optional tail result carrying the flags
    typedef struct packed {
        logic [MAX_DELIM_BYTES-1:0][7:0] bytes;
        logic [LEN_W-1:0]                cnt;
        logic                            tail;
        logic                            tail_end;
        logic                            tail_done;
        logic                            tail_err;
    } t_batch;

    // one result item
    typedef struct packed {
        logic [7:0] token_byte;
        logic       byte_valid;
        logic       token_end;
        logic       all_done;
        logic       error_flag;
    } t_result;

endpackage
`default_nettype wire

// ----- sv/ssd_step.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssd_step: next-state and result logic for one string byte
// Compares the window plus the new byte against the delimiter at every
// shift in parallel and picks the smallest shift that leaves a prefix.
// ----------------------------------------------------------------------------
module ssd_step (
    input  logic [7:0]                   i_byte,
    input  ssd_pkg::t_state              i_state,
    input  logic [ssd_pkg::DELIM_W-1:0]  i_delim,
    input  logic [ssd_pkg::LEN_W-1:0]    i_dlen,
    input  logic [ssd_pkg::LIMIT_W-1:0]  i_limit,
    output ssd_pkg::t_state              o_state,
    output ssd_pkg::t_batch              o_batch
);

    logic [ssd_pkg::MAX_DELIM_BYTES-1:0][7:0] dl;
    logic [ssd_pkg::MAX_DELIM_BYTES-1:0][7:0] wext;
    logic [ssd_pkg::MAX_DELIM_BYTES-1:0]      ok;
    logic [ssd_pkg::LEN_W-1:0]                len;
    logic [ssd_pkg::LEN_W-1:0]                m;
    logic [ssd_pkg::LEN_W-1:0]                sel;
    logic [ssd_pkg::LEN_W-1:0]                rem;
    logic                                     matching;
    logic                                     hit;

    assign dl = i_delim;

    always_comb begin
        // clamp oversized length
        len = (i_dlen > ssd_pkg::LEN_W'(ssd_pkg::MAX_DELIM_BYTES))
            ? ssd_pkg::LEN_W'(ssd_pkg::MAX_DELIM_BYTES) : i_dlen;
        matching = (len != '0) &&
                   (i_limit[ssd_pkg::LIMIT_W-1] ||
                    (i_state.splits < i_limit[ssd_pkg::LIMIT_W-2:0]));

        // window with the new byte appended
        for (int i = 0; i < ssd_pkg::MAX_DELIM_BYTES; i++) begin
            if (ssd_pkg::LEN_W'(i) < ssd_pkg::LEN_W'(i_state.wcnt)) begin
                wext[i] = i_state.window[i];
            end else if (ssd_pkg::LEN_W'(i) == ssd_pkg::LEN_W'(i_state.wcnt)) begin
                wext[i] = i_byte;
            end else begin
                wext[i] = '0;
            end
        end
        m = ssd_pkg::LEN_W'(i_state.wcnt) + ssd_pkg::LEN_W'(1);

        // shift s is good when the rest fits in the delimiter and is a prefix;
        // dropping every byte is always good and is the fallback below
        for (int s = 0; s < ssd_pkg::MAX_DELIM_BYTES; s++) begin
            ok[s] = (ssd_pkg::LEN_W'(s) <= m) && ((m - ssd_pkg::LEN_W'(s)) <= len);
            for (int i = 0; i < ssd_pkg::MAX_DELIM_BYTES; i++) begin
                if (s + i < ssd_pkg::MAX_DELIM_BYTES) begin
                    if ((ssd_pkg::LEN_W'(i) < (m - ssd_pkg::LEN_W'(s))) &&
                        (wext[ssd_pkg::WCNT_W'(s + i)] != dl[i])) begin
                        ok[s] = 1'b0;
                    end
                end
            end
        end

        sel = ssd_pkg::LEN_W'(ssd_pkg::MAX_DELIM_BYTES);
        for (int s = ssd_pkg::MAX_DELIM_BYTES - 1; s >= 0; s--) begin
            if (ok[s]) begin
                sel = ssd_pkg::LEN_W'(s);
            end
        end
        rem = m - sel;
        hit = (rem == len);

        o_state         = i_state;
        o_batch         = '0;
        o_batch.bytes   = wext;

        if (i_byte == 8'd0) begin
            // terminator: error result, or flush the window and end the token
            o_batch.tail      = 1'b1;
            o_batch.tail_done = 1'b1;
            if ((len == '0) || (i_state.slen == '0) || i_state.ovf) begin
                o_batch.tail_err = 1'b1;
            end else begin
                o_batch.cnt      = ssd_pkg::LEN_W'(i_state.wcnt);
                o_batch.tail_end = 1'b1;
            end
            o_state = '0;
        end else begin
            if (i_state.slen >= ssd_pkg::SLEN_MAX) begin
                o_state.ovf = 1'b1;
            end else begin
                o_state.slen = i_state.slen + ssd_pkg::SLEN_W'(1);
            end

            if (!matching) begin
                o_batch.cnt    = m;
                o_state.window = '0;
                o_state.wcnt   = '0;
            end else begin
                o_batch.cnt = sel;
                if (hit) begin
                    o_batch.tail     = 1'b1;
                    o_batch.tail_end = 1'b1;
                    o_state.window   = '0;
                    o_state.wcnt     = '0;
                    if (i_state.splits != ssd_pkg::SPLITS_MAX) begin
                        o_state.splits = i_state.splits + ssd_pkg::SPLIT_W'(1);
                    end
                end else begin
                    o_state.window = wext >> {sel, 3'b000};
                    o_state.wcnt   = rem[ssd_pkg::WCNT_W-1:0];
                end
            end
        end
    end

endmodule
`default_nettype wire

// ----- sv/string_split_by_delimiter.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Output: the first result of an item is registered in the output register before it shows on the output.
// Throughput: one item per cycle while each item yields at most one result and the output is
//   not stalled; an item that yields more than one result (window flush on a mismatch, a
//   match, or the terminator) holds the input while its pending results drain through the output register.
// Reset: synchronous, active low; clears string state, pending results and output valid,
//   and loads the registers with delimiter ',', length 1 and an unlimited split count.
// ----------------------------------------------------------------------------
// string_split_by_delimiter: streaming string splitter with a split limit
// Cuts a zero-terminated byte stream into tokens at leftmost non-overlapping
// delimiter matches, emitting token bytes, token ends, errors and a final marker.
// ----------------------------------------------------------------------------
module string_split_by_delimiter (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input stream
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [7:0]                    i_s_axis_tdata,   // [7:0] str_byte
    // result stream
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    output logic [7:0]                    o_m_axis_tdata,   // [7:0] token_byte
    output logic [2:0]                    o_m_axis_tuser,   // [0] byte_valid, [1] token_end,
                                                            // [2] error_flag
    output logic                          o_m_axis_tlast,   // all_done
    // configuration writes
    input  logic                          i_cfg_we,
    input  logic [1:0]                    i_cfg_idx,
    input  logic [ssd_pkg::CFG_W-1:0]     i_cfg_data
);

    // configuration registers
    logic [ssd_pkg::DELIM_W-1:0] r_delim;
    logic [ssd_pkg::LEN_W-1:0]   r_dlen;
    logic [ssd_pkg::LIMIT_W-1:0] r_limit;

    ssd_pkg::t_state  r_state, step_state;
    ssd_pkg::t_batch  r_pend, n_pend, step_batch, src;
    ssd_pkg::t_result r_out, n_out;
    logic             r_ovalid, n_ovalid;
    logic             pend_empty;
    logic             accept;
    logic             load;

    // one byte's worth of matching, all combinational
    ssd_step u_step (
        .i_byte  (i_s_axis_tdata),
        .i_state (r_state),
        .i_delim (r_delim),
        .i_dlen  (r_dlen),
        .i_limit (r_limit),
        .o_state (step_state),
        .o_batch (step_batch)
    );

    always_comb begin
        // take a new item only once the previous item's results have all
        // moved into the output register
        pend_empty = (r_pend.cnt == '0) && !r_pend.tail;
        accept     = i_s_axis_tvalid && pend_empty;

        // results still pending, else the batch of the item taken now
        if (!pend_empty) begin
            src = r_pend;
        end else if (accept) begin
            src = step_batch;
        end else begin
            src = '0;
        end

        // advance the output register when it is empty or being taken
        load = (!r_ovalid || i_m_axis_tready) && ((src.cnt != '0) || src.tail);

        n_out  = '0;
        n_pend = src;
        if (src.cnt != '0) begin
            // token bytes go first, in order
            n_out.token_byte = src.bytes[0];
            n_out.byte_valid = 1'b1;
            if (load) begin
                n_pend.bytes = src.bytes >> 8;
                n_pend.cnt   = src.cnt - ssd_pkg::LEN_W'(1);
            end
        end else begin
            // then the flag result, if any
            n_out.token_end  = src.tail_end;
            n_out.all_done   = src.tail_done;
            n_out.error_flag = src.tail_err;
            if (load) begin
                n_pend.tail      = 1'b0;
                n_pend.tail_end  = 1'b0;
                n_pend.tail_done = 1'b0;
                n_pend.tail_err  = 1'b0;
            end
        end

        if (load) begin
            n_ovalid = 1'b1;
        end else if (i_m_axis_tready) begin
            n_ovalid = 1'b0;
        end else begin
            n_ovalid = r_ovalid;
        end
    end

    // control state and string state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= '0;
            r_pend   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_pend   <= n_pend;
            r_ovalid <= n_ovalid;
            if (accept) begin
                r_state <= step_state;
            end
        end
    end

    // output payload, held while stalled
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= n_out;
        end
    end

    // configuration writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delim <= ssd_pkg::DELIM_RESET;
            r_dlen  <= ssd_pkg::DLEN_RESET;
            r_limit <= ssd_pkg::LIMIT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                ssd_pkg::CFG_DELIM_BYTES: begin
                    r_delim <= i_cfg_data;
                end
                ssd_pkg::CFG_DELIM_LEN: begin
                    r_dlen <= i_cfg_data[ssd_pkg::LEN_W-1:0];
                end
                ssd_pkg::CFG_SPLIT_LIMIT: begin
                    r_limit <= i_cfg_data[ssd_pkg::LIMIT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_s_axis_tready = pend_empty;
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_out.token_byte;
    assign o_m_axis_tuser  = {r_out.error_flag, r_out.token_end, r_out.byte_valid};
    assign o_m_axis_tlast  = r_out.all_done;

endmodule
`default_nettype wire

// ----- sv/ssd_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssd_checker: port-level checks on the splitter's result stream
// Watches the result channel and reset, and is bound to the top level.
// ----------------------------------------------------------------------------
module ssd_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_m_tvalid,
    input  logic       i_m_tready,
    input  logic [7:0] i_m_tdata,
    input  logic [2:0] i_m_tuser,
    input  logic       i_m_tlast
);

    // no result in the cycle after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !i_m_tvalid)
        else $error("result valid right after reset");

    // a token byte is never the terminator, and a flag result carries no byte
    a_byte_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid |-> (i_m_tuser[0] == (i_m_tdata != 8'd0)))
        else $error("token byte and byte_valid disagree");

    // the last result of a string is a token end or an error
    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && i_m_tlast |-> !i_m_tuser[0] && (i_m_tuser[1] != i_m_tuser[2]))
        else $error("final result has wrong flags");

    // an error result always closes the string
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && i_m_tuser[2] |-> i_m_tlast)
        else $error("error result without all_done");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=> i_m_tvalid && $stable(i_m_tdata) &&
            $stable(i_m_tuser) && $stable(i_m_tlast))
        else $error("stalled result changed");

endmodule

bind string_split_by_delimiter ssd_checker u_ssd_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_m_tvalid (o_m_axis_tvalid),
    .i_m_tready (i_m_axis_tready),
    .i_m_tdata  (o_m_axis_tdata),
    .i_m_tuser  (o_m_axis_tuser),
    .i_m_tlast  (o_m_axis_tlast)
);
`default_nettype wire
